### src/inorm_pkg.sv
package inorm_pkg;

  localparam int unsigned MaxCountDefault = 65536;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 33;
  localparam int unsigned SqSumW  = 47;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned OffsetW = 48;
  localparam int unsigned AluW    = 64;
  localparam int unsigned EpsW    = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // 64 passes for multiply and divide, 32 for the square root
  localparam logic [5:0] LongPasses = 6'd63;
  localparam logic [5:0] RootPasses = 6'd31;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_FINAL = 2'd1,
    OP_NORM  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ALU_MUL  = 3'b001,
    ALU_DIV  = 3'b010,
    ALU_SQRT = 3'b100
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [0:0] {
    REG_EPSILON = 1'b0,
    REG_AFFINE  = 1'b1
  } reg_idx_t;

endpackage

### src/inorm_intf.sv
interface inorm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [15:0] sample;
  logic signed [15:0] gamma;
  logic signed [15:0] beta;

  modport source (output valid, op, sample, gamma, beta, input ready);
  modport sink (input valid, op, sample, gamma, beta, output ready);
endinterface

interface inorm_result_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] normalized;

  modport source (output valid, normalized, input ready);
  modport sink (input valid, normalized, output ready);
endinterface

### src/inorm_alu.sv
module inorm_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  inorm_pkg::alu_req_t       req,
  input  logic [inorm_pkg::AluW-1:0] a,
  input  logic [inorm_pkg::AluW-1:0] b,
  output logic                      done,
  output logic [inorm_pkg::AluW-1:0] res
);

  logic                      busy;
  logic [5:0]                cnt;
  inorm_pkg::alu_op_t        op_r;
  logic [inorm_pkg::AluW-1:0] acc;
  logic [inorm_pkg::AluW-1:0] opa;
  logic [inorm_pkg::AluW-1:0] opb;
  logic [inorm_pkg::AluW-1:0] rem;

  logic [inorm_pkg::AluW:0]   div_r2;
  logic                       div_ge;
  logic [inorm_pkg::AluW:0]   div_rem_next;
  logic [inorm_pkg::AluW-1:0] sq_sum;
  logic                       sq_ge;
  logic [inorm_pkg::AluW-1:0] mul_sum;

  always_comb begin
    div_r2       = {rem, opa[inorm_pkg::AluW-1]};
    div_ge       = div_r2 >= {1'b0, opb};
    div_rem_next = div_ge ? div_r2 - {1'b0, opb} : div_r2;
    sq_sum       = acc + opb;
    sq_ge        = opa >= sq_sum;
    mul_sum      = acc + opa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == inorm_pkg::ALU_SQRT) ? inorm_pkg::RootPasses
                                                 : inorm_pkg::LongPasses;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      acc  <= '0;
      rem  <= '0;
      opa  <= a;
      case (req.op)
        inorm_pkg::ALU_SQRT: opb <= {2'b01, {(inorm_pkg::AluW-2){1'b0}}};
        default:             opb <= b;
      endcase
    end else if (busy) begin
      case (op_r)
        inorm_pkg::ALU_MUL: begin
          if (opb[0]) acc <= mul_sum;
          opa <= opa << 1;
          opb <= opb >> 1;
        end
        inorm_pkg::ALU_DIV: begin
          rem <= div_rem_next[inorm_pkg::AluW-1:0];
          acc <= {acc[inorm_pkg::AluW-2:0], div_ge};
          opa <= opa << 1;
        end
        inorm_pkg::ALU_SQRT: begin
          if (sq_ge) begin
            opa <= opa - sq_sum;
            acc <= (acc >> 1) + opb;
          end else begin
            acc <= acc >> 1;
          end
          opb <= opb >> 2;
        end
        default: acc <= acc;
      endcase
    end
  end

  assign res = acc;

endmodule

### src/instance_normalization_core.sv
// Instance normalization, one channel at a time, Q8.8 fixed point.
// Items enter on the item channel (valid/ready, op + sample/gamma/beta);
// normalized samples leave on the result channel (valid/ready).
// Accumulate items are accepted one per cycle and stream back to back.
// A normalize item passes through S_NORM_MUL, which registers the product,
// and S_NORM_OUT, which loads the result register; the core is ready again
// as soon as the result register is loaded.
// A finalize item runs a sequence on one shared bit-serial unit: four
// multiplies and three divides of 64 passes and one 32-pass square root,
// the scale divide being skipped when the root is zero; an empty channel
// skips the sequence. The core holds ready low during that sequence.
// While the receiver stalls, a pending normalize result holds in the output
// register and the core waits in its last normalize step.
// Reset (synchronous, rst high) clears counts, sums, scale and offset and
// sets epsilon to 1 and affine_on to 1. Registers are written over the APB
// port: epsilon at 0x0, affine_on at 0x4; write them only while idle.
module instance_normalization_core #(
  parameter int unsigned MAX_COUNT = inorm_pkg::MaxCountDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  inorm_item_if.sink                    item,
  inorm_result_if.source                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [inorm_pkg::AddrW-1:0]   paddr,
  input  logic [inorm_pkg::DataW-1:0]   pwdata,
  output logic [inorm_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned CntW = $clog2(MAX_COUNT + 1);
  localparam int unsigned AW   = inorm_pkg::AluW;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_NORM_MUL  = 5'b00010,
    S_NORM_OUT  = 5'b00100,
    S_FIN_START = 5'b01000,
    S_FIN_WAIT  = 5'b10000
  } state_t;

  typedef enum logic [7:0] {
    ST_NSQ  = 8'b00000001,
    ST_SS   = 8'b00000010,
    ST_NN   = 8'b00000100,
    ST_VAR  = 8'b00001000,
    ST_SQRT = 8'b00010000,
    ST_Q    = 8'b00100000,
    ST_PROD = 8'b01000000,
    ST_FD   = 8'b10000000
  } step_t;

  state_t state;
  step_t  step;

  logic [inorm_pkg::EpsW-1:0]          epsilon;
  logic                                affine_on;
  logic [CntW-1:0]                     count;
  logic signed [inorm_pkg::SumW-1:0]   sum;
  logic [inorm_pkg::SqSumW-1:0]        sqsum;
  logic signed [inorm_pkg::ScaleW-1:0] scale;
  logic signed [inorm_pkg::OffsetW-1:0] offset;

  logic [AW-1:0]                       w0;
  logic [AW-1:0]                       w1;
  logic signed [inorm_pkg::ScaleW-1:0] sc_r;
  logic signed [15:0]                  g_r;
  logic signed [15:0]                  b_r;
  logic signed [15:0]                  x_r;
  logic                                neg_r;
  logic signed [47:0]                  norm_prod;

  logic                                out_valid;
  logic signed [15:0]                  out_data;

  logic                                accept;
  logic signed [15:0]                  g_sel;
  logic signed [15:0]                  b_sel;
  logic signed [31:0]                  x_sq;
  logic [AW-1:0]                       n64;
  logic [32:0]                         sum_mag;
  logic [32:0]                         sc_mag;
  logic [16:0]                         g_mag;
  logic [AW-1:0]                       fd;
  logic signed [48:0]                  norm_acc;
  logic signed [32:0]                  norm_shr;
  logic signed [15:0]                  norm_sat;
  logic                                out_load;

  inorm_pkg::alu_req_t                 alu_req;
  logic [AW-1:0]                       alu_a;
  logic [AW-1:0]                       alu_b;
  logic                                alu_done;
  logic [AW-1:0]                       alu_res;

  inorm_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign g_sel      = affine_on ? item.gamma : 16'sd256;
  assign b_sel      = affine_on ? item.beta : 16'sd0;
  assign x_sq       = item.sample * item.sample;
  assign n64        = AW'(count);
  assign sum_mag    = sum[inorm_pkg::SumW-1] ? 33'(-sum) : 33'(sum);
  assign sc_mag     = sc_r[31] ? 33'(0) - {1'b1, sc_r} : {1'b0, sc_r};
  assign g_mag      = g_r[15] ? 17'(0) - {1'b1, g_r} : {1'b0, g_r};
  assign fd         = neg_r ? AW'(0) - alu_res : alu_res;

  // operands for the current finalize step
  always_comb begin
    alu_req.start = (state == S_FIN_START);
    alu_req.op    = inorm_pkg::ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (step)
      ST_NSQ: begin
        alu_a = n64;
        alu_b = AW'(sqsum);
      end
      ST_SS: begin
        alu_a = AW'(sum_mag);
        alu_b = AW'(sum_mag);
      end
      ST_NN: begin
        alu_a = n64;
        alu_b = n64;
      end
      ST_VAR: begin
        alu_req.op = inorm_pkg::ALU_DIV;
        alu_a      = w0;
        alu_b      = w1;
      end
      ST_SQRT: begin
        alu_req.op = inorm_pkg::ALU_SQRT;
        alu_a      = w0;
      end
      ST_Q: begin
        alu_req.op = inorm_pkg::ALU_DIV;
        alu_a      = AW'(g_mag) << 24;
        alu_b      = w1;
      end
      ST_PROD: begin
        alu_a = AW'(sum_mag);
        alu_b = AW'(sc_mag);
      end
      ST_FD: begin
        alu_req.op = inorm_pkg::ALU_DIV;
        alu_a      = w0;
        alu_b      = n64;
      end
      default: alu_a = '0;
    endcase
  end

  always_comb begin
    norm_acc = {norm_prod[47], norm_prod} + {offset[47], offset};
    norm_shr = norm_acc[48:16];
    if (norm_shr > 33'sd32767) begin
      norm_sat = 16'sh7fff;
    end else if (norm_shr < -33'sd32768) begin
      norm_sat = -16'sh8000;
    end else begin
      norm_sat = norm_shr[15:0];
    end
  end

  assign out_load = (state == S_NORM_OUT) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_NSQ;
      count     <= '0;
      sum       <= '0;
      sqsum     <= '0;
      scale     <= '0;
      offset    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.op)
              inorm_pkg::OP_ACCUM: begin
                if (count < CntW'(MAX_COUNT)) begin
                  count <= count + CntW'(1);
                  sum   <= sum + inorm_pkg::SumW'(item.sample);
                  sqsum <= sqsum + inorm_pkg::SqSumW'(unsigned'(x_sq));
                end
              end
              inorm_pkg::OP_FINAL: begin
                if (count == '0) begin
                  scale  <= '0;
                  offset <= {{16{b_sel[15]}}, b_sel, 16'h0};
                end else begin
                  step  <= ST_NSQ;
                  state <= S_FIN_START;
                end
              end
              inorm_pkg::OP_NORM: state <= S_NORM_MUL;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_NORM_MUL: state <= S_NORM_OUT;
        S_NORM_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        S_FIN_START: state <= S_FIN_WAIT;
        S_FIN_WAIT: begin
          if (alu_done) begin
            state <= S_FIN_START;
            case (step)
              ST_NSQ:  step <= ST_SS;
              ST_SS:   step <= ST_NN;
              ST_NN:   step <= ST_VAR;
              ST_VAR:  step <= ST_SQRT;
              ST_SQRT: step <= (alu_res == '0) ? ST_PROD : ST_Q;
              ST_Q:    step <= ST_PROD;
              ST_PROD: step <= ST_FD;
              ST_FD: begin
                state  <= S_IDLE;
                scale  <= sc_r;
                offset <= {{16{b_r[15]}}, b_r, 16'h0} - fd[inorm_pkg::OffsetW-1:0];
                count  <= '0;
                sum    <= '0;
                sqsum  <= '0;
              end
              default: step <= ST_NSQ;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // finalize working registers and normalize datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      g_r <= g_sel;
      b_r <= b_sel;
      x_r <= item.sample;
    end
    if (state == S_NORM_MUL) begin
      norm_prod <= 48'(x_r * scale);
    end
    if (out_load) begin
      out_data <= norm_sat;
    end
    if (state == S_FIN_WAIT && alu_done) begin
      case (step)
        ST_NSQ: w0 <= alu_res;
        ST_SS:  w0 <= w0 - alu_res;
        ST_NN:  w1 <= alu_res;
        ST_VAR: w0 <= (alu_res + AW'(epsilon)) << 16;
        ST_SQRT: begin
          w1 <= alu_res;
          if (alu_res == '0) begin
            if (g_r > 16'sd0) begin
              sc_r <= 32'sh7fff_ffff;
            end else if (g_r < 16'sd0) begin
              sc_r <= 32'sh8000_0000;
            end else begin
              sc_r <= '0;
            end
          end
        end
        ST_Q: begin
          if (g_r[15]) begin
            sc_r <= (alu_res > 64'h8000_0000) ? 32'sh8000_0000
                                              : 32'(32'd0 - alu_res[31:0]);
          end else begin
            sc_r <= (alu_res > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(alu_res[31:0]);
          end
        end
        ST_PROD: begin
          neg_r <= sum[inorm_pkg::SumW-1] ^ sc_r[31];
          w0    <= (sum[inorm_pkg::SumW-1] ^ sc_r[31]) ? alu_res + n64 - AW'(1)
                                                       : alu_res;
        end
        default: w0 <= w0;
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.normalized = out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon   <= inorm_pkg::EpsW'(1);
      affine_on <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (inorm_pkg::reg_idx_t'(paddr[2]))
        inorm_pkg::REG_EPSILON: epsilon   <= pwdata[inorm_pkg::EpsW-1:0];
        inorm_pkg::REG_AFFINE:  affine_on <= pwdata[0];
        default:                affine_on <= affine_on;
      endcase
    end
  end

  always_comb begin
    case (inorm_pkg::reg_idx_t'(paddr[2]))
      inorm_pkg::REG_EPSILON: prdata = inorm_pkg::DataW'(epsilon);
      inorm_pkg::REG_AFFINE:  prdata = inorm_pkg::DataW'(affine_on);
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule
